// File: hw/rtl/uhc_pkg.sv
// Shared types, constants and the one's-complement fold for the UDP checksum block.
package uhc_pkg;

    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;
    // Four 16-bit operands summed before folding fit in 18 bits.
    localparam int WIDE_W  = WORD_W + 2;

    localparam logic [WORD_W-1:0] SRC_PORT_RST      = 16'd26;
    localparam logic [WORD_W-1:0] DST_PORT_RST      = 16'd26;
    localparam logic [WORD_W-1:0] LENGTH_WORD_RST   = 16'd10;
    localparam logic [WORD_W-1:0] CHECKSUM_WORD_RST = 16'd0;
    localparam logic              CHECKSUM_EN_RST   = 1'b1;
    localparam logic [WORD_W-1:0] WORD_ONES         = 16'hFFFF;

    typedef enum logic [INDEX_W-1:0] {
        CFG_SRC_PORT      = 3'd0,
        CFG_DST_PORT      = 3'd1,
        CFG_LENGTH_WORD   = 3'd2,
        CFG_CHECKSUM_WORD = 3'd3,
        CFG_CHECKSUM_EN   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [WORD_W-1:0] hdr_sum;
        logic [WORD_W-1:0] checksum_word;
        logic              checksum_enable;
    } uhc_cfg_t;

    // End-around carry fold of a wide sum; result is zero only for a zero sum.
    function automatic logic [WORD_W-1:0] oc_fold(input logic [WIDE_W-1:0] wide);
        logic [WORD_W:0] first;
        logic [WORD_W:0] second;
        first  = {1'b0, wide[WORD_W-1:0]} + {{(WORD_W+1-(WIDE_W-WORD_W)){1'b0}},
                                              wide[WIDE_W-1:WORD_W]};
        second = {1'b0, first[WORD_W-1:0]} + {{WORD_W{1'b0}}, first[WORD_W]};
        return second[WORD_W-1:0];
    endfunction

endpackage

// File: hw/rtl/uhc_cfg_regs.sv
// Configuration registers and the registered sum of the four header words.
module uhc_cfg_regs
    import uhc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]  wr_data,
    output uhc_cfg_t           cfg
);

    logic [WORD_W-1:0] src_port_reg;
    logic [WORD_W-1:0] src_port_next;
    logic [WORD_W-1:0] dst_port_reg;
    logic [WORD_W-1:0] dst_port_next;
    logic [WORD_W-1:0] length_word_reg;
    logic [WORD_W-1:0] length_word_next;
    logic [WORD_W-1:0] checksum_word_reg;
    logic [WORD_W-1:0] checksum_word_next;
    logic              checksum_enable_reg;
    logic              checksum_enable_next;
    logic [WORD_W-1:0] hdr_sum_reg;
    logic [WORD_W-1:0] hdr_sum_next;

    always_comb
    begin
        src_port_next        = src_port_reg;
        dst_port_next        = dst_port_reg;
        length_word_next     = length_word_reg;
        checksum_word_next   = checksum_word_reg;
        checksum_enable_next = checksum_enable_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_SRC_PORT:      src_port_next        = wr_data;
                CFG_DST_PORT:      dst_port_next        = wr_data;
                CFG_LENGTH_WORD:   length_word_next     = wr_data;
                CFG_CHECKSUM_WORD: checksum_word_next   = wr_data;
                CFG_CHECKSUM_EN:   checksum_enable_next = wr_data[0];
                default:           ;
            endcase
        end
    end

    // Fold the header sum from the values taking effect at this edge, so it
    // never lags the registers it is built from.
    assign hdr_sum_next = oc_fold({2'b00, src_port_next} + {2'b00, dst_port_next}
                                + {2'b00, length_word_next} + {2'b00, checksum_word_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_port_reg        <= SRC_PORT_RST;
            dst_port_reg        <= DST_PORT_RST;
            length_word_reg     <= LENGTH_WORD_RST;
            checksum_word_reg   <= CHECKSUM_WORD_RST;
            checksum_enable_reg <= CHECKSUM_EN_RST;
            hdr_sum_reg         <= oc_fold({2'b00, SRC_PORT_RST} + {2'b00, DST_PORT_RST}
                                         + {2'b00, LENGTH_WORD_RST}
                                         + {2'b00, CHECKSUM_WORD_RST});
        end
        else
        begin
            src_port_reg        <= src_port_next;
            dst_port_reg        <= dst_port_next;
            length_word_reg     <= length_word_next;
            checksum_word_reg   <= checksum_word_next;
            checksum_enable_reg <= checksum_enable_next;
            hdr_sum_reg         <= hdr_sum_next;
        end
    end

    assign cfg.hdr_sum         = hdr_sum_reg;
    assign cfg.checksum_word   = checksum_word_reg;
    assign cfg.checksum_enable = checksum_enable_reg;

endmodule

// File: hw/rtl/uhc_core.sv
// Input register, byte pairing and running sum, and the result register.
module uhc_core
    import uhc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  uhc_cfg_t          cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] payload_byte,
    input  logic              byte_valid,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] checksum_field
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_bv_reg;
    logic              s1_last_reg;

    logic [WORD_W-1:0] running_sum_reg;
    logic [WORD_W-1:0] running_sum_next;
    logic [BYTE_W-1:0] held_reg;
    logic [BYTE_W-1:0] held_next;
    logic              odd_reg;
    logic              odd_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] field_reg;

    logic              in_accept;
    logic              out_free;
    logic              drain;
    logic              close;
    logic [WORD_W-1:0] pair_word;
    logic [WORD_W-1:0] pad_word;
    logic [WORD_W-1:0] pair_sum;
    logic [WORD_W-1:0] total_sum;
    logic [WORD_W-1:0] result;

    assign out_free  = !out_valid_reg || !out_stall;
    assign drain     = s1_valid_reg && (!s1_last_reg || out_free);
    assign close     = drain && s1_last_reg;
    assign in_stall  = s1_valid_reg && !drain;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next = in_accept || (s1_valid_reg && !drain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= payload_byte;
            s1_bv_reg   <= byte_valid;
            s1_last_reg <= last;
        end
    end

    // A byte completes a pair when one is held; a lone byte at close pads low.
    assign pair_word = (s1_bv_reg && odd_reg) ? {held_reg, s1_byte_reg} : '0;

    always_comb
    begin
        pad_word = '0;
        if (s1_bv_reg && !odd_reg)
            pad_word = {s1_byte_reg, {BYTE_W{1'b0}}};
        else if (!s1_bv_reg && odd_reg)
            pad_word = {held_reg, {BYTE_W{1'b0}}};
    end

    assign pair_sum  = oc_fold({2'b00, running_sum_reg} + {2'b00, pair_word});
    assign total_sum = oc_fold({2'b00, running_sum_reg} + {2'b00, pair_word}
                             + {2'b00, pad_word} + {2'b00, cfg.hdr_sum});
    assign result    = cfg.checksum_enable ? (total_sum ^ WORD_ONES) : cfg.checksum_word;

    always_comb
    begin
        running_sum_next = running_sum_reg;
        held_next        = held_reg;
        odd_next         = odd_reg;
        if (close)
        begin
            running_sum_next = '0;
            held_next        = '0;
            odd_next         = 1'b0;
        end
        else if (drain && s1_bv_reg)
        begin
            if (odd_reg)
            begin
                running_sum_next = pair_sum;
                held_next        = '0;
                odd_next         = 1'b0;
            end
            else
            begin
                held_next = s1_byte_reg;
                odd_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            held_reg        <= '0;
            odd_reg         <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            held_reg        <= held_next;
            odd_reg         <= odd_next;
        end
    end

    assign out_valid_next = close || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (close)
            field_reg <= result;
    end

    assign out_valid      = out_valid_reg;
    assign checksum_field = field_reg;

endmodule

// File: hw/rtl/udp_header_checksum.sv
// Top level of the streaming UDP header checksum generator.
//
// Payload bytes of one segment enter on the input channel (in_valid /
// in_stall), one transfer per byte in segment order. A transfer with
// byte_valid low carries no byte; with last high it closes the segment,
// which is how an empty payload is ended. Bytes pair into 16-bit words,
// first byte high; a lone final byte is padded with a zero low byte.
// Header words come from the write port (wr_en / wr_index / wr_data);
// write them only while no transfer is in flight.
// Each transfer with last high yields one output transfer: the inverted
// one's-complement sum of header and payload, or the configured checksum
// word when insertion is disabled.
// One transfer per cycle is taken while in_stall is low. An item enters the
// input register; the end-around carry add feeds the result register, so
// a result passes the input and result registers before out_valid rises.
// While the result register is full and out_stall is high, a last item
// waits in the input register and in_stall rises; other items keep going.
// rst_n clears the segment sum and both valid flags and loads the
// default header words (ports 26, length 10, checksum 0, insertion on).
module udp_header_checksum
    import uhc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]  wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  payload_byte,
    input  logic               byte_valid,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [WORD_W-1:0]  checksum_field
);

    uhc_cfg_t cfg;

    // Hold header words and their pre-folded sum.
    uhc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Advance bytes through pairing and summing; drop the result into the
    // output register on the last transfer.
    uhc_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .checksum_field (checksum_field)
    );

endmodule

// File: hw/rtl/uhc_checker.sv
// Port-level assertions for the UDP checksum block, bound to the top level.
module uhc_checker
    import uhc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               last,
    input logic               out_valid,
    input logic               out_stall,
    input logic [WORD_W-1:0]  checksum_field
);

    // Hold a stalled result.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(checksum_field))
        else $error("result changed while stalled");

    // A new result comes only from an earlier accepted last transfer.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
        else $error("result without a closing transfer");

    // Input backpressure only while a result is waiting.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

endmodule

bind udp_header_checksum uhc_checker u_checker (.*);
